// ===== hdl/pmq_pkg.sv =====
// Shared types, codes and widths of the priority message queue.
`default_nettype none
package pmq_pkg;

  // Default geometry.
  localparam int DEPTH_DEF     = 16;
  localparam int MSG_BYTES_DEF = 8;
  localparam int PRIO_BITS_DEF = 8;

  // Fixed port widths.
  localparam int DATA_W     = 64;
  localparam int LEN_W      = 4;
  localparam int REQ_PRIO_W = 8;
  localparam int BUF_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int CAP_W      = 5;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Register reset values.
  localparam logic [CAP_W-1:0]   CAP_RST   = 5'd16;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY   = 1'b0,
    CFG_SIZE_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_RECV = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_SMALL_BUF = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND_RD,
    S_SEND_CMP,
    S_SEND_PUT,
    S_RECV_RD,
    S_RECV_MOVE
  } state_e;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic [CAP_W-1:0]   capacity;
    logic [LIMIT_W-1:0] size_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/pmq_ram.sv =====
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module pmq_ram #(
  parameter int WIDTH = 76,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/pmq_seq.sv =====
// Sequencer: request checks, sorted insert and head removal over the entry memory.
`default_nettype none
module pmq_seq #(
  parameter int DEPTH     = pmq_pkg::DEPTH_DEF,
  parameter int MSG_BYTES = pmq_pkg::MSG_BYTES_DEF,
  parameter int PRIO_BITS = pmq_pkg::PRIO_BITS_DEF,
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int DW  = MSG_BYTES * 8,
  localparam int EW  = PRIO_BITS + pmq_pkg::LEN_W + DW
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pmq_pkg::cfg_t                    cfg_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             operation_i,
  input  wire logic [pmq_pkg::DATA_W-1:0]       message_data_i,
  input  wire logic [pmq_pkg::LEN_W-1:0]        message_length_i,
  input  wire logic [pmq_pkg::REQ_PRIO_W-1:0]   priority_req_i,
  input  wire logic [pmq_pkg::BUF_W-1:0]        buffer_length_i,
  output logic                                  out_valid_o,
  output logic [pmq_pkg::STATUS_W-1:0]          status_o,
  output logic [pmq_pkg::DATA_W-1:0]            out_data_o,
  output logic [pmq_pkg::LEN_W-1:0]             out_length_o,
  output logic [pmq_pkg::REQ_PRIO_W-1:0]        out_priority_o,
  output logic                                  mem_we_o,
  output logic [AW-1:0]                         mem_waddr_o,
  output logic [EW-1:0]                         mem_wdata_o,
  output logic [AW-1:0]                         mem_raddr_o,
  input  wire logic [EW-1:0]                    mem_rdata_i
);
  import pmq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

  function automatic logic [DW-1:0] keep_bytes(input logic [DW-1:0] d,
                                               input logic [LEN_W-1:0] n);
    logic [DW-1:0] r;
    r = '0;
    for (int b = 0; b < MSG_BYTES; b++) begin
      if (LEN_W'(b) < n) begin
        r[b*8 +: 8] = d[b*8 +: 8];
      end
    end
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [EW-1:0]      ent_q, ent_d;
  logic               vld_q, vld_d;
  status_e            status_q, status_d;
  logic [DW-1:0]      odata_q, odata_d;
  logic [LEN_W-1:0]   olen_q, olen_d;
  logic [PRIO_BITS-1:0] oprio_q, oprio_d;

  logic               accept;
  logic [CAPW-1:0]    cap_ext;
  logic [CW-1:0]      cap_eff;
  logic [LIMIT_W-1:0] limit_eff;
  logic               send_long, send_full, recv_small, recv_empty;
  logic [CW-1:0]      idx_m1, idx_p1;
  logic [PRIO_BITS-1:0] rd_prio, new_prio;
  logic               hit;

  // Effective configuration.
  always_comb begin
    cap_ext = CAPW'(cfg_i.capacity);
    if (cap_ext < CAPW'(2)) begin
      cap_eff = CW'(2);
    end else if (cap_ext > CAPW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_ext);
    end
    if (cfg_i.size_limit > LIMIT_W'(MSG_BYTES)) begin
      limit_eff = LIMIT_W'(MSG_BYTES);
    end else begin
      limit_eff = cfg_i.size_limit;
    end
  end

  assign accept     = start && (state_q == S_IDLE);
  assign busy       = (state_q != S_IDLE);
  assign send_long  = message_length_i > limit_eff;
  assign send_full  = ((CW+1)'(count_q) + (CW+1)'(1)) >= (CW+1)'(cap_eff);
  assign recv_small = buffer_length_i < BUF_W'(limit_eff);
  assign recv_empty = (count_q == '0);

  assign idx_m1   = idx_q - CW'(1);
  assign idx_p1   = idx_q + CW'(1);
  assign rd_prio  = mem_rdata_i[EW-1 -: PRIO_BITS];
  assign new_prio = ent_q[EW-1 -: PRIO_BITS];
  // The shared compare: new item goes behind equal or higher priority.
  assign hit      = rd_prio >= new_prio;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_SEND) begin
            if (send_long || send_full) begin
              state_d = S_IDLE;
            end else if (count_q == '0) begin
              state_d = S_SEND_PUT;
            end else begin
              state_d = S_SEND_RD;
            end
          end else if (!(recv_small || recv_empty)) begin
            state_d = S_RECV_RD;
          end
        end
      end
      S_SEND_RD:  state_d = S_SEND_CMP;
      S_SEND_CMP: begin
        if (hit || (idx_q == CW'(1))) begin
          state_d = S_SEND_PUT;
        end else begin
          state_d = S_SEND_RD;
        end
      end
      S_SEND_PUT: state_d = S_IDLE;
      S_RECV_RD:  state_d = S_RECV_MOVE;
      S_RECV_MOVE: begin
        if (idx_p1 == count_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_RECV_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    ent_d       = ent_q;
    vld_d       = 1'b0;
    status_d    = status_q;
    odata_d     = odata_q;
    olen_d      = olen_q;
    oprio_d     = oprio_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AW-1:0];
    mem_wdata_o = ent_q;
    mem_raddr_o = idx_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ent_d = {PRIO_BITS'(priority_req_i), message_length_i,
                   keep_bytes(message_data_i[DW-1:0], message_length_i)};
          if (operation_i == OP_SEND) begin
            idx_d = count_q;
            if (send_long || send_full) begin
              vld_d    = 1'b1;
              status_d = send_long ? ST_TOO_LONG : ST_FULL;
              odata_d  = '0;
              olen_d   = '0;
              oprio_d  = '0;
            end
          end else begin
            idx_d = '0;
            if (recv_small || recv_empty) begin
              vld_d    = 1'b1;
              status_d = recv_small ? ST_SMALL_BUF : ST_EMPTY;
              odata_d  = '0;
              olen_d   = '0;
              oprio_d  = '0;
            end
          end
        end
      end
      S_SEND_RD: begin
        mem_raddr_o = idx_m1[AW-1:0];
      end
      S_SEND_CMP: begin
        if (!hit) begin
          // Lower priority entry moves one slot toward the tail.
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_m1;
        end
      end
      S_SEND_PUT: begin
        mem_we_o = 1'b1;
        count_d  = count_q + CW'(1);
        vld_d    = 1'b1;
        status_d = ST_OK;
        odata_d  = '0;
        olen_d   = '0;
        oprio_d  = '0;
      end
      S_RECV_RD: begin
      end
      S_RECV_MOVE: begin
        if (idx_q == '0) begin
          odata_d = mem_rdata_i[DW-1:0];
          olen_d  = mem_rdata_i[DW +: LEN_W];
          oprio_d = rd_prio;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_m1[AW-1:0];
          mem_wdata_o = mem_rdata_i;
        end
        idx_d = idx_p1;
        if (idx_p1 == count_q) begin
          count_d  = count_q - CW'(1);
          vld_d    = 1'b1;
          status_d = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ent_q    <= ent_d;
    status_q <= status_d;
    odata_q  <= odata_d;
    olen_q   <= olen_d;
    oprio_q  <= oprio_d;
  end

  assign out_valid_o    = vld_q;
  assign status_o       = status_q;
  assign out_data_o     = DATA_W'(odata_q);
  assign out_length_o   = olen_q;
  assign out_priority_o = REQ_PRIO_W'(oprio_q);

endmodule
`default_nettype wire

// ===== hdl/priority_message_queue.sv =====
// Top level of the priority message queue: configuration registers and entry store.
//
// Bounded message queue kept sorted by priority, highest first; equal
// priorities leave in arrival order.
// Request channel: an item (operation, message, priority, buffer size) is
//   taken at a rising edge with start high and busy low.
// Result channel: one result per item, shown for exactly one cycle with
//   out_valid_o high. The receiver cannot stall, so nothing waits.
// Config: cfg_we_i writes capacity (index 0) or size limit (index 1) at once.
// Flow per item; busy falls as the result is shown:
//   rejected (too long, full, empty, small buffer): decided in idle, busy stays low.
//   send: held entries are read and compared from the tail toward the head; each
//   of lower priority moves back one slot; the new item is then written behind the
//   first of equal or higher priority, or at the head if there is none.
//   receive: head read, then each remaining entry moves forward.
// Every visited entry goes through the single read port of the entry memory, whose
// read data is registered, so each is read in one state and used in the next.
// Reset empties the queue at once and loads capacity 16, size limit 8; the
// entry memory itself is not cleared.
`default_nettype none
module priority_message_queue #(
  parameter int DEPTH     = pmq_pkg::DEPTH_DEF,
  parameter int MSG_BYTES = pmq_pkg::MSG_BYTES_DEF,
  parameter int PRIO_BITS = pmq_pkg::PRIO_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             operation_i,
  input  wire logic [pmq_pkg::DATA_W-1:0]       message_data_i,
  input  wire logic [pmq_pkg::LEN_W-1:0]        message_length_i,
  input  wire logic [pmq_pkg::REQ_PRIO_W-1:0]   priority_req_i,
  input  wire logic [pmq_pkg::BUF_W-1:0]        buffer_length_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pmq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                                  out_valid_o,
  output logic [pmq_pkg::STATUS_W-1:0]          status_o,
  output logic [pmq_pkg::DATA_W-1:0]            out_data_o,
  output logic [pmq_pkg::LEN_W-1:0]             out_length_o,
  output logic [pmq_pkg::REQ_PRIO_W-1:0]        out_priority_o
);
  import pmq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = MSG_BYTES * 8;
  localparam int EW = PRIO_BITS + LEN_W + DW;

  cfg_t cfg_q;

  // Memory port between sequencer and entry store.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  // Configuration registers; raw values are kept, clamping is done in use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity   <= CAP_RST;
      cfg_q.size_limit <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CAPACITY:   cfg_q.capacity   <= cfg_wdata_i[CAP_W-1:0];
        CFG_SIZE_LIMIT: cfg_q.size_limit <= cfg_wdata_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pmq_seq #(
    .DEPTH     (DEPTH),
    .MSG_BYTES (MSG_BYTES),
    .PRIO_BITS (PRIO_BITS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .message_data_i   (message_data_i),
    .message_length_i (message_length_i),
    .priority_req_i   (priority_req_i),
    .buffer_length_i  (buffer_length_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .out_data_o       (out_data_o),
    .out_length_o     (out_length_o),
    .out_priority_o   (out_priority_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  // Entries kept sorted, head at address 0.
  pmq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

// ===== hdl/pmq_checker.sv =====
// Port-level checks of the priority message queue and their binding.
`default_nettype none
module pmq_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             operation_i,
  input wire logic                             out_valid_o,
  input wire logic [pmq_pkg::STATUS_W-1:0]     status_o,
  input wire logic [pmq_pkg::DATA_W-1:0]       out_data_o,
  input wire logic [pmq_pkg::LEN_W-1:0]        out_length_o,
  input wire logic [pmq_pkg::REQ_PRIO_W-1:0]   out_priority_o
);
  import pmq_pkg::*;

  // Work only starts on an accepted item.
  a_busy_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // Leaving the busy phase always delivers the result.
  a_result_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_valid_o)
    else $error("busy fell without a result");

  // A failed request carries no message.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |->
      ((out_data_o == '0) && (out_length_o == '0) && (out_priority_o == '0)))
    else $error("failed request returned message fields");

  // Too long is decided at once, for a send only.
  a_too_long_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_TOO_LONG)) |->
      $past(start && !busy && (operation_i == OP_SEND)))
    else $error("too long reported without a send just before");

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (.*);
`default_nettype wire
